>>> design/image_convolution_3x3_saturating_assert.svh
// Assertion macros used by the port-level checker of the 3x3 convolution block.
// No dependencies; the caller provides clock and reset signal names.
`ifndef IMAGE_CONVOLUTION_3X3_SATURATING_ASSERT_SVH
`define IMAGE_CONVOLUTION_3X3_SATURATING_ASSERT_SVH

// checked only while out of reset
`define ICV_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ICV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/icv_pkg.sv
// Package of the 3x3 convolution block: sizes, codes, command and result types.
// No dependencies.
package icv_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int FRAC_BITS    = 8;
    localparam int KERNEL_SIZE  = 3;

    localparam int PIX_W   = 17;
    localparam int COEF_W  = 16;
    localparam int ROW_CW  = KERNEL_SIZE * COEF_W;
    localparam int SIZE_W  = 11;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(HEIGHT_LIMIT);
    localparam int PROD_W  = COEF_W + PIX_W;
    localparam int GRP_W   = PROD_W + 2;
    localparam int SUM_W   = GRP_W + 2;
    localparam int TAPS    = KERNEL_SIZE * KERNEL_SIZE;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_CW;

    localparam int CQ_DEPTH  = 4;
    localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);

    localparam int OFIFO_DEPTH = 8;
    localparam int OPTR_W      = $clog2(OFIFO_DEPTH);
    localparam int OCNT_W      = $clog2(OFIFO_DEPTH + 1);
    localparam int STAGES      = 5;
    localparam int FLY_W       = $clog2(STAGES + 1);

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_MIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_MAX = 3'd7;

    typedef struct packed {
        logic [ROW_CW-1:0]        coef_top;
        logic [ROW_CW-1:0]        coef_mid;
        logic [ROW_CW-1:0]        coef_bot;
        logic [SIZE_W-1:0]        width;
        logic [SIZE_W-1:0]        height;
        logic                     border_zero;
        logic signed [PIX_W-1:0]  clamp_min;
        logic signed [PIX_W-1:0]  clamp_max;
    } t_cfg;

    typedef struct packed {
        logic                     is_pix;
        logic signed [PIX_W-1:0]  pixel;
        logic [COL_W-1:0]         col;
        logic                     emit;
        logic                     conv;
        logic                     sel_b;
        logic                     last;
    } t_cmd;

    typedef struct packed {
        logic                     emit;
        logic                     conv;
        logic                     last;
        logic signed [PIX_W-1:0]  center;
    } t_tag;

    typedef struct packed {
        logic signed [PIX_W-1:0]  pixel;
        logic                     last;
    } t_res;

    function automatic logic signed [COEF_W-1:0] coef_at(logic [ROW_CW-1:0] row, int j);
        return $signed(row[COEF_W*j +: COEF_W]);
    endfunction

endpackage

>>> design/icv_if.sv
// Stream interfaces of the 3x3 convolution block: pixel input and result output.
// Depends on icv_pkg.
interface icv_in_if import icv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    op;
    logic signed [PIX_W-1:0] pixel_in;
    modport source (output valid, op, pixel_in, input ready);
    modport sink   (input valid, op, pixel_in, output ready);
endinterface

interface icv_out_if import icv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] pixel_out;
    logic                    frame_last;
    modport source (output valid, pixel_out, frame_last, input ready);
    modport sink   (input valid, pixel_out, frame_last, output ready);
endinterface

>>> design/icv_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module icv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

>>> design/icv_front.sv
// Front end: accepts pixel and drain transfers, tracks raster positions and
// pending outputs, and issues commands to the queue. Depends on icv_pkg, icv_if.
module icv_front import icv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_clr,
    icv_in_if.sink      i_pix,
    input  logic        i_full,
    output logic        o_push,
    output t_cmd        o_cmd
);
    logic [COL_W-1:0]  r_in_col, r_out_col;
    logic [ROW_W-1:0]  r_in_row, r_out_row;
    logic [SIZE_W-1:0] r_pend;

    logic              acc, is_pix, emit, border, last_col, last_row, full_pend, any_pend;
    logic              in_col_end, in_row_end;
    logic [SIZE_W-1:0] wp1;

    assign wp1        = i_cfg.width + SIZE_W'(1);
    assign full_pend  = r_pend == wp1;
    assign any_pend   = r_pend != '0;
    assign acc        = i_pix.valid && i_pix.ready;
    assign is_pix     = i_pix.op == OP_PIXEL;
    assign emit       = is_pix ? full_pend : any_pend;
    assign last_col   = SIZE_W'(r_out_col) + SIZE_W'(1) == i_cfg.width;
    assign last_row   = SIZE_W'(r_out_row) + SIZE_W'(1) == i_cfg.height;
    assign border     = r_out_row == '0 || last_row || r_out_col == '0 || last_col;
    assign in_col_end = SIZE_W'(r_in_col) + SIZE_W'(1) == i_cfg.width;
    assign in_row_end = SIZE_W'(r_in_row) + SIZE_W'(1) == i_cfg.height;

    assign i_pix.ready = !i_full;
    assign o_push      = acc && (is_pix || any_pend);

    always_comb begin
        o_cmd.is_pix = is_pix;
        o_cmd.pixel  = i_pix.pixel_in;
        o_cmd.col    = is_pix ? r_in_col : r_out_col;
        o_cmd.emit   = emit;
        o_cmd.conv   = is_pix && !border;
        o_cmd.sel_b  = full_pend;
        o_cmd.last   = last_row && last_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pend    <= '0;
        end else if (acc) begin
            if (is_pix) begin
                if (in_col_end) begin
                    r_in_col <= '0;
                    r_in_row <= in_row_end ? '0 : r_in_row + ROW_W'(1);
                end else begin
                    r_in_col <= r_in_col + COL_W'(1);
                end
            end
            if (emit) begin
                if (last_col) begin
                    r_out_col <= '0;
                    r_out_row <= last_row ? '0 : r_out_row + ROW_W'(1);
                end else begin
                    r_out_col <= r_out_col + COL_W'(1);
                end
            end
            if (is_pix && !emit) begin
                r_pend <= r_pend + SIZE_W'(1);
            end else if (!is_pix && emit) begin
                r_pend <= r_pend - SIZE_W'(1);
            end
        end
    end
endmodule

>>> design/icv_cmd_queue.sv
// Short command queue between front and back end.
// Depends on icv_pkg.
module icv_cmd_queue import icv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_cmd o_cmd
);
    t_cmd                r_mem [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wp, r_rp;
    logic [CQ_CNT_W-1:0] r_cnt;

    assign o_valid = r_cnt != '0;
    assign o_full  = r_cnt == CQ_CNT_W'(CQ_DEPTH);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + CQ_PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + CQ_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CQ_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CQ_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

>>> design/icv_back.sv
// Back end: line stores, 3x3 window, multiply and sum pipeline, rounding,
// clamping and the output queue. Depends on icv_pkg, icv_if, icv_ram.
module icv_back import icv_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_pop,
    icv_out_if.source o_pix
);
    // stage valids and payloads
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    t_cmd r_c1;
    t_tag r_t2, r_t3, r_t4, r_t5;

    // output queue
    t_res              r_omem [OFIFO_DEPTH];
    logic [OPTR_W-1:0] r_owp, r_orp;
    logic [OCNT_W-1:0] r_ocnt;

    logic [FLY_W-1:0]  fly;
    logic              opush, opop;

    assign fly = FLY_W'(r_v1) + FLY_W'(r_v2) + FLY_W'(r_v3) + FLY_W'(r_v4) + FLY_W'(r_v5);
    assign o_pop = i_cmd_valid &&
        ((OCNT_W+1)'(r_ocnt) + (OCNT_W+1)'(fly) < (OCNT_W+1)'(OFIFO_DEPTH));

    // line stores: near holds the previous row, far the row before
    logic [PIX_W-1:0]        q_near, q_far;
    logic                    wr_en;
    logic                    r_fwd;
    logic signed [PIX_W-1:0] r_fwd_near, r_fwd_far;
    logic signed [PIX_W-1:0] a, b;

    assign wr_en = r_v1 && r_c1.is_pix;
    assign a = r_fwd ? r_fwd_near : $signed(q_near);
    assign b = r_fwd ? r_fwd_far  : $signed(q_far);

    icv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_near (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_c1.col),
        .i_wdata (r_c1.pixel),
        .i_raddr (i_cmd.col),
        .o_rdata (q_near)
    );

    icv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_far (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_c1.col),
        .i_wdata (a),
        .i_raddr (i_cmd.col),
        .o_rdata (q_far)
    );

    always_ff @(posedge i_clk) begin
        r_fwd      <= wr_en && r_c1.col == i_cmd.col;
        r_fwd_near <= r_c1.pixel;
        r_fwd_far  <= a;
    end

    // window shift
    logic signed [PIX_W-1:0] r_win [TAPS];
    logic signed [PIX_W-1:0] n_win [TAPS];
    t_tag                    n_t2;

    always_comb begin
        n_win = r_win;
        if (wr_en) begin
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                n_win[r*3]     = r_win[r*3 + 1];
                n_win[r*3 + 1] = r_win[r*3 + 2];
            end
            n_win[2] = b;
            n_win[5] = a;
            n_win[8] = r_c1.pixel;
        end
        n_t2.emit   = r_c1.emit;
        n_t2.conv   = r_c1.conv;
        n_t2.last   = r_c1.last;
        n_t2.center = r_c1.is_pix ? r_win[5] : (r_c1.sel_b ? b : a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_win <= n_win;
        end
    end

    // products, reflected mask
    logic signed [PROD_W-1:0] n_p [TAPS];
    logic signed [PROD_W-1:0] r_p [TAPS];
    logic [ROW_CW-1:0]        rows [KERNEL_SIZE];

    assign rows[0] = i_cfg.coef_top;
    assign rows[1] = i_cfg.coef_mid;
    assign rows[2] = i_cfg.coef_bot;

    always_comb begin
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            for (int j = 0; j < KERNEL_SIZE; j++) begin
                n_p[i*3 + j] = PROD_W'(coef_at(rows[i], j)) *
                               PROD_W'(r_win[(2 - i)*3 + (2 - j)]);
            end
        end
    end

    // sums
    logic signed [GRP_W-1:0] n_g [KERNEL_SIZE];
    logic signed [GRP_W-1:0] r_g [KERNEL_SIZE];
    logic signed [SUM_W-1:0] r_sum;

    always_comb begin
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            n_g[i] = GRP_W'(r_p[i*3]) + GRP_W'(r_p[i*3 + 1]) + GRP_W'(r_p[i*3 + 2]);
        end
    end

    // truncate toward zero, clamp, border select
    localparam logic signed [SUM_W-1:0] RND = SUM_W'((1 << FRAC_BITS) - 1);
    logic signed [SUM_W-1:0] adj, v, lo, hi, cl;
    t_res                    res;

    always_comb begin
        adj = r_sum + (r_sum[SUM_W-1] ? RND : SUM_W'(0));
        v   = adj >>> FRAC_BITS;
        lo  = SUM_W'(i_cfg.clamp_min);
        hi  = SUM_W'(i_cfg.clamp_max);
        cl  = (v < hi) ? ((v < lo) ? lo : v) : hi;
        if (r_t5.conv) begin
            res.pixel = PIX_W'(cl);
        end else begin
            res.pixel = i_cfg.border_zero ? PIX_W'(0) : r_t5.center;
        end
        res.last = r_t5.last;
    end

    always_ff @(posedge i_clk) begin
        r_c1  <= i_cmd;
        r_t2  <= n_t2;
        r_t3  <= r_t2;
        r_t4  <= r_t3;
        r_t5  <= r_t4;
        r_p   <= n_p;
        r_g   <= n_g;
        r_sum <= SUM_W'(r_g[0]) + SUM_W'(r_g[1]) + SUM_W'(r_g[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // output queue
    assign opush = r_v5 && r_t5.emit;
    assign opop  = o_pix.valid && o_pix.ready;

    assign o_pix.valid      = r_ocnt != '0;
    assign o_pix.pixel_out  = r_omem[r_orp].pixel;
    assign o_pix.frame_last = r_omem[r_orp].last;

    always_ff @(posedge i_clk) begin
        if (opush) begin
            r_omem[r_owp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (opush) begin
                r_owp <= r_owp + OPTR_W'(1);
            end
            if (opop) begin
                r_orp <= r_orp + OPTR_W'(1);
            end
            case ({opush, opop})
                2'b10:   r_ocnt <= r_ocnt + OCNT_W'(1);
                2'b01:   r_ocnt <= r_ocnt - OCNT_W'(1);
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end
endmodule

>>> design/image_convolution_3x3_saturating.sv
// Top level of the 3x3 saturating convolution: configuration registers,
// front end, command queue, back end. Depends on icv_pkg, icv_if and submodules.
//
// Usage: pixels enter on i_pix in raster order (op = pixel), one transfer per
// clock while ready. Results leave on o_pix in raster order, W+1 positions behind the
// input; frame_last marks the last position of a frame. Drain transfers
// (op = drain) flush pending outputs at the end of a frame, one per drain.
// Throughput: one transfer per cycle in and out unless a queue fills or the
// receiver stalls, set by one read and one write of each line store per item.
// Path from input transfer to result: command queue, line store read, window,
// multiply, two adder levels; round and clamp feed the output queue write.
// The user writes configuration via i_cfg_we/i_cfg_index/i_cfg_data only while
// idle, unchecked by the block; a width/height write restarts the raster position.
// Reset clears positions, window and queues; line stores are not cleared.
// When the receiver stalls, results collect in an 8-entry output queue;
// the back end stops taking commands when that queue could overflow and
// the front end stalls once its 4-entry command queue fills.
module image_convolution_3x3_saturating import icv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    icv_in_if.sink                i_pix,
    icv_out_if.source             o_pix,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic [ROW_CW-1:0]       r_coef_top, r_coef_mid, r_coef_bot;
    logic [SIZE_W-1:0]       r_width, r_height;
    logic                    r_border;
    logic signed [PIX_W-1:0] r_cmin, r_cmax;
    t_cfg                    cfg;
    logic                    clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top <= '0;
            r_coef_mid <= '0;
            r_coef_bot <= '0;
            r_width    <= SIZE_W'(MAX_WIDTH);
            r_height   <= SIZE_W'(HEIGHT_LIMIT);
            r_border   <= 1'b0;
            r_cmin     <= '0;
            r_cmax     <= PIX_W'(65535);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_COEF_TOP:  r_coef_top <= i_cfg_data;
                REG_COEF_MID:  r_coef_mid <= i_cfg_data;
                REG_COEF_BOT:  r_coef_bot <= i_cfg_data;
                REG_WIDTH:     r_width    <= i_cfg_data[SIZE_W-1:0];
                REG_HEIGHT:    r_height   <= i_cfg_data[SIZE_W-1:0];
                REG_BORDER:    r_border   <= i_cfg_data[0];
                REG_CLAMP_MIN: r_cmin     <= i_cfg_data[PIX_W-1:0];
                REG_CLAMP_MAX: r_cmax     <= i_cfg_data[PIX_W-1:0];
                default:       r_border   <= r_border;
            endcase
        end
    end

    assign clr = i_cfg_we && (i_cfg_index == REG_WIDTH || i_cfg_index == REG_HEIGHT);

    always_comb begin
        cfg.coef_top    = r_coef_top;
        cfg.coef_mid    = r_coef_mid;
        cfg.coef_bot    = r_coef_bot;
        cfg.width       = (r_width < SIZE_W'(KERNEL_SIZE)) ? SIZE_W'(KERNEL_SIZE) :
                          (r_width > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : r_width;
        cfg.height      = (r_height < SIZE_W'(KERNEL_SIZE)) ? SIZE_W'(KERNEL_SIZE) :
                          (r_height > SIZE_W'(HEIGHT_LIMIT)) ? SIZE_W'(HEIGHT_LIMIT) : r_height;
        cfg.border_zero = r_border;
        cfg.clamp_min   = r_cmin;
        cfg.clamp_max   = r_cmax;
    end

    logic push, full, cq_valid, pop;
    t_cmd cmd_in, cmd_out;

    icv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_clr   (clr),
        .i_pix   (i_pix),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd_in)
    );

    icv_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_valid (cq_valid),
        .o_full  (full),
        .o_cmd   (cmd_out)
    );

    icv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (cq_valid),
        .i_cmd       (cmd_out),
        .o_pop       (pop),
        .o_pix       (o_pix)
    );
endmodule

>>> design/icv_checker.sv
// Port-level checker for the 3x3 convolution top level, attached by bind.
// Depends on icv_pkg and image_convolution_3x3_saturating_assert.svh.
`include "image_convolution_3x3_saturating_assert.svh"

module icv_checker import icv_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [PIX_W-1:0] i_out_pixel,
    input logic                    i_out_last
);
    `ICV_ASSERT_ALWAYS(a_no_out_after_rst, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")
    `ICV_ASSERT_ALWAYS(a_ready_after_rst, i_clk, !i_rst_n |=> i_in_ready, "input not ready after reset")
    `ICV_ASSERT_RST(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pixel) && $stable(i_out_last), "stalled result changed")
endmodule

bind image_convolution_3x3_saturating icv_checker u_icv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_pixel (o_pix.pixel_out),
    .i_out_last  (o_pix.frame_last)
);

>>> sim/testbench.sv
// Self-checking testbench of the 3x3 saturating convolution block.
// Depends on icv_pkg, icv_if and the block; predicts or tabulates each result.
module testbench;
    import icv_pkg::*;

    localparam int LIMIT = 1000000;
    localparam int LAT   = 30;
    localparam int RAND_ITEMS = 1000;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_exp;

    typedef struct {
        logic             op;
        logic [PIX_W-1:0] pixel;
        bit               typed;
        logic [PIX_W-1:0] epix;
        logic             elast;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    icv_in_if  pix_if();
    icv_out_if res_if();

    image_convolution_3x3_saturating uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(pix_if), .o_pix(res_if),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [ROW_CW-1:0] coef [0:2];
    int               cfg_w, cfg_h;
    bit               zero_border;
    logic [PIX_W-1:0] lim_lo, lim_hi;
    logic [PIX_W-1:0] lines [0:2*MAX_WIDTH-1];
    logic [PIX_W-1:0] win [0:8];
    int in_r, in_c, out_r, out_c;

    t_exp pending_res[$];
    int   errors;
    int   cycles;
    bit   calm;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic int eff_w();
        return cfg_w < 3 ? 3 : (cfg_w > MAX_WIDTH ? MAX_WIDTH : cfg_w);
    endfunction

    function automatic int eff_h();
        return cfg_h < 3 ? 3 : (cfg_h > HEIGHT_LIMIT ? HEIGHT_LIMIT : cfg_h);
    endfunction

    function automatic logic [PIX_W-1:0] conv_sum();
        longint sum, v;
        logic signed [COEF_W-1:0] cw;
        logic signed [PIX_W-1:0]  px;
        logic signed [PIX_W-1:0]  lo, hi;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                cw = coef[i][COEF_W*j +: COEF_W];
                px = win[(2-i)*3 + (2-j)];
                sum += longint'(cw) * longint'(px);
            end
        end
        v = sum >= 0 ? (sum >>> FRAC_BITS) : -((-sum) >>> FRAC_BITS);
        lo = lim_lo;
        hi = lim_hi;
        v = (v < longint'(hi)) ? ((v < longint'(lo)) ? longint'(lo) : v) : longint'(hi);
        return v[PIX_W-1:0];
    endfunction

    function automatic void advance(ref int r, ref int c, input int w, input int h);
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
    endfunction

    function automatic t_exp next_output(logic [PIX_W-1:0] center, bit use_win);
        t_exp e;
        int w, h;
        bit edge_pos;
        w = eff_w();
        h = eff_h();
        edge_pos = out_r == 0 || out_r == h-1 || out_c == 0 || out_c == w-1;
        if (edge_pos || !use_win) e.pixel = zero_border ? '0 : center;
        else e.pixel = conv_sum();
        e.last = (out_r == h-1 && out_c == w-1);
        advance(out_r, out_c, w, h);
        return e;
    endfunction

    function automatic bit conv_step(logic op, logic [PIX_W-1:0] pix, output t_exp e);
        int w, h, tot, pend, c;
        logic [PIX_W-1:0] a, b;
        w = eff_w();
        h = eff_h();
        tot = w * h;
        pend = ((in_r*w + in_c) + tot - (out_r*w + out_c)) % tot;
        if (op == OP_PIXEL) begin
            c = in_c % MAX_WIDTH;
            a = lines[c];
            b = lines[MAX_WIDTH + c];
            lines[MAX_WIDTH + c] = a;
            lines[c] = pix;
            for (int r = 0; r < 3; r++) begin
                win[r*3] = win[r*3+1];
                win[r*3+1] = win[r*3+2];
            end
            win[2] = b;
            win[5] = a;
            win[8] = pix;
            advance(in_r, in_c, w, h);
            if (pend == w + 1) begin
                e = next_output(win[4], 1'b1);
                return 1'b1;
            end
            return 1'b0;
        end
        if (pend == 0) return 1'b0;
        c = out_c % MAX_WIDTH;
        a = (pend == w + 1) ? lines[MAX_WIDTH + c] : lines[c];
        e = next_output(a, 1'b0);
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // result side: random stalls, compare against the oldest expectation
    initial begin
        int stall;
        t_exp got, want;
        stall = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                got.pixel = res_if.pixel_out;
                got.last  = res_if.frame_last;
                if (pending_res.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: pixel %h last %b", got.pixel, got.last);
                end else begin
                    want = pending_res.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected pixel %h last %b, got pixel %h last %b",
                                     want.pixel, want.last, got.pixel, got.last);
                    end
                end
            end
            if (stall > 0) begin
                stall--;
                res_if.ready <= 1'b0;
            end else begin
                stall = pick_gap();
                res_if.ready <= (stall == 0);
            end
        end
    end

    task automatic send_item(logic op, logic [PIX_W-1:0] pix, bit typed = 0,
                             t_exp typed_res = '0, output bit produced);
        int gap;
        t_exp e;
        gap = pick_gap();
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid    <= 1'b1;
        pix_if.op       <= op;
        pix_if.pixel_in <= pix;
        do @(posedge i_clk); while (!pix_if.ready);
        produced = conv_step(op, pix, e);
        if (typed) pending_res.push_back(typed_res);
        else if (produced) pending_res.push_back(e);
    endtask

    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            REG_COEF_TOP:  coef[0] = data;
            REG_COEF_MID:  coef[1] = data;
            REG_COEF_BOT:  coef[2] = data;
            REG_WIDTH, REG_HEIGHT: begin
                if (idx == REG_WIDTH) cfg_w = data[SIZE_W-1:0];
                else cfg_h = data[SIZE_W-1:0];
                in_r = 0; in_c = 0; out_r = 0; out_c = 0;
            end
            REG_BORDER:    zero_border = data[0];
            REG_CLAMP_MIN: lim_lo = data[PIX_W-1:0];
            default:       lim_hi = data[PIX_W-1:0];
        endcase
    endtask

    task automatic set_config(logic [ROW_CW-1:0] t, logic [ROW_CW-1:0] m,
                              logic [ROW_CW-1:0] b, int w, int h, bit bz,
                              logic [PIX_W-1:0] lo, logic [PIX_W-1:0] hi);
        wait_idle();
        cfg_write(REG_COEF_TOP, t);
        cfg_write(REG_COEF_MID, m);
        cfg_write(REG_COEF_BOT, b);
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
        cfg_write(REG_BORDER, bz);
        cfg_write(REG_CLAMP_MIN, lo);
        cfg_write(REG_CLAMP_MAX, hi);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [ROW_CW-1:0] rand_coef_row();
        logic [ROW_CW-1:0] r;
        for (int j = 0; j < 3; j++) begin
            if ($urandom_range(0, 2) == 0) r[COEF_W*j +: COEF_W] = $urandom;
            else r[COEF_W*j +: COEF_W] = $urandom_range(0, 1024) - 512;
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return 17'h0FFFF;
            1: return 17'h10000;
            2: return 17'h1FFFF;
            3: return '0;
            4, 5: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        t_row dir [$];
        t_exp te;
        bit   got;
        int   done, w, h, frames, lw, lh, np, nd;
        logic [PIX_W-1:0] lo, hi;

        errors = 0;
        cycles = 0;
        calm = 1'b0;
        coef[0] = '0; coef[1] = '0; coef[2] = '0;
        cfg_w = 1024; cfg_h = 1024;
        zero_border = 1'b0;
        lim_lo = '0; lim_hi = 17'h0FFFF;
        for (int i = 0; i < 2*MAX_WIDTH; i++) lines[i] = '0;
        for (int i = 0; i < 9; i++) win[i] = '0;
        in_r = 0; in_c = 0; out_r = 0; out_c = 0;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        pix_if.valid = 1'b0;
        pix_if.op = OP_PIXEL;
        pix_if.pixel_in = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x3 image, identity mask: borders pass through, centre is clamped
        set_config('0, {16'd0, 16'd256, 16'd0}, '0, 3, 3, 1'b0, '0, 17'h0FFFF);
        dir = '{
            '{OP_DRAIN, 17'h00000, 1, 17'h00000, 0},
            '{OP_PIXEL, 17'h0FFFF, 0, 17'h00000, 0},
            '{OP_PIXEL, 17'h10000, 0, 17'h00000, 0},
            '{OP_PIXEL, 17'h00000, 0, 17'h00000, 0},
            '{OP_PIXEL, 17'h00001, 0, 17'h00000, 0},
            '{OP_PIXEL, 17'h10000, 1, 17'h0FFFF, 0},
            '{OP_PIXEL, 17'h00005, 1, 17'h10000, 0},
            '{OP_PIXEL, 17'h00006, 1, 17'h00000, 0},
            '{OP_PIXEL, 17'h00007, 1, 17'h00001, 0},
            '{OP_PIXEL, 17'h00008, 1, 17'h00000, 0},
            '{OP_DRAIN, 17'h1FFFF, 1, 17'h00005, 0},
            '{OP_DRAIN, 17'h00000, 1, 17'h00006, 0},
            '{OP_DRAIN, 17'h00000, 1, 17'h00007, 0},
            '{OP_DRAIN, 17'h00000, 1, 17'h00008, 1},
            '{OP_DRAIN, 17'h00000, 0, 17'h00000, 0}
        };
        foreach (dir[k]) begin
            te.pixel = dir[k].epix;
            te.last  = dir[k].elast;
            // the leading drain is idle and must produce nothing
            send_item(dir[k].op, dir[k].pixel, dir[k].typed && k != 0, te, got);
        end

        // zero border, full-range clamp, hot weights
        set_config({3{16'h7FFF}}, {3{16'h8000}}, {3{16'hFFFF}}, 4, 3, 1'b1,
                   17'h10000, 17'h0FFFF);
        for (int k = 0; k < 12; k++) send_item(OP_PIXEL, rand_pixel(), 0, '0, got);
        for (int k = 0; k < 5; k++) send_item(OP_DRAIN, '0, 0, '0, got);

        done = 0;
        for (int ph = 0; done < RAND_ITEMS || ph < 8; ph++) begin
            calm = (ph % 5 == 4);
            if (ph == 2) begin lw = 2047; lh = 3; end
            else if (ph == 5) begin lw = 0; lh = 2047; end
            else if (ph == 7) begin lw = 1; lh = 2; end
            else begin lw = $urandom_range(3, 8); lh = $urandom_range(3, 6); end
            case ($urandom_range(0, 3))
                0: begin lo = 17'h10000; hi = 17'h0FFFF; end
                1: begin lo = $urandom; hi = $urandom; end
                default: begin lo = '0; hi = 17'h0FFFF; end
            endcase
            set_config(rand_coef_row(), rand_coef_row(), rand_coef_row(), lw, lh,
                       $urandom_range(0, 1), lo, hi);
            w = eff_w();
            h = eff_h();
            frames = (w * h > 100) ? 1 : $urandom_range(1, 3);
            // large images are sent in part and then drained
            np = (w * h > 150) ? 150 : w * h;
            for (int f = 0; f < frames; f++) begin
                for (int p = 0; p < np; p++) begin
                    if ($urandom_range(0, 39) == 0) begin
                        send_item(OP_DRAIN, $urandom, 0, '0, got);
                        if (got) done++;
                    end
                    send_item(OP_PIXEL, rand_pixel(), 0, '0, got);
                    done++;
                end
                if (f == frames - 1 || $urandom_range(0, 1) == 0) begin
                    nd = ((np < w + 1) ? np : w + 1) + $urandom_range(0, 2);
                    for (int d = 0; d < nd; d++) begin
                        send_item(OP_DRAIN, $urandom, 0, '0, got);
                        if (got) done++;
                    end
                end
            end
        end

        pix_if.valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
        if (errors == 0 && pending_res.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+design
design/icv_pkg.sv
design/icv_if.sv
design/icv_ram.sv
design/icv_front.sv
design/icv_cmd_queue.sv
design/icv_back.sv
design/image_convolution_3x3_saturating.sv
design/icv_checker.sv
sim/testbench.sv
